// ===== rtl/core/path_statistics_with_drawdown_defines.svh =====
// Assertion macros used by the control module of the path statistics block.
`ifndef PATH_STATISTICS_WITH_DRAWDOWN_DEFINES_SVH
`define PATH_STATISTICS_WITH_DRAWDOWN_DEFINES_SVH

`ifndef SYNTHESIS
`define PSDD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PSDD_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define PSDD_ASSERT(lbl, clk, rstn, prop, msg)
`define PSDD_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== rtl/core/psdd_pkg.sv =====
package psdd_pkg;

  localparam int MaxSamples = 4096;
  localparam int PriceW     = 24;
  localparam int CntW       = 13;
  localparam int SumW       = 36;
  localparam int SqW        = 60;
  localparam int DivW       = 74;
  localparam int DivCntW    = 7;
  localparam int VarW       = 48;
  localparam int SqrtSteps  = 24;
  localparam int IdxW       = 6;
  localparam int DdW        = 16;

  typedef enum logic [1:0] {
    DivMean,
    DivVar,
    DivDd
  } div_sel_t;

  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [PriceW-1:0] mean_price;
    logic [PriceW-1:0] std_dev;
    logic [PriceW-1:0] max_price;
    logic [PriceW-1:0] min_price;
    logic [PriceW-1:0] final_price;
    logic [DdW-1:0]    max_drawdown;
    logic [CntW-1:0]   sample_count;
    logic              too_long;
  } out_word_t;

  typedef struct packed {
    logic            acc;
    logic            prep;
    logic            mul_a;
    logic            mul_b;
    logic            div_start;
    logic            div_ld;
    div_sel_t        div_sel;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            out_ld;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/core/psdd_div.sv =====
module psdd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psdd_pkg::DivW-1:0]   dividend,
  input  logic [psdd_pkg::PriceW-1:0] divisor,
  output logic [psdd_pkg::DivW-1:0]   quotient,
  output logic                        done
);

  logic [psdd_pkg::DivW-1:0]    q_r;
  logic [psdd_pkg::PriceW-1:0]  r_r;
  logic [psdd_pkg::PriceW-1:0]  d_r;
  logic [psdd_pkg::DivCntW-1:0] n_r;
  logic                         busy_r;
  logic                         done_r;
  logic [psdd_pkg::PriceW:0]    rs;
  logic [psdd_pkg::PriceW:0]    diff;
  logic                         ge;

  assign rs   = {r_r, q_r[psdd_pkg::DivW-1]};
  assign diff = rs - {1'b0, d_r};
  assign ge   = rs >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && n_r == psdd_pkg::DivCntW'(psdd_pkg::DivW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
      n_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[psdd_pkg::DivW-2:0], ge};
      r_r <= ge ? diff[psdd_pkg::PriceW-1:0] : rs[psdd_pkg::PriceW-1:0];
      n_r <= n_r + 1'b1;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// ===== rtl/core/psdd_datapath.sv =====
module psdd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psdd_pkg::cmd_t       cmd,
  input  psdd_pkg::in_word_t   in_word,
  output psdd_pkg::sts_t       sts,
  output psdd_pkg::out_word_t  out_word
);

  localparam int PW = psdd_pkg::PriceW;

  logic [psdd_pkg::CntW-1:0] cnt_r;
  logic [psdd_pkg::SumW-1:0] sum_r;
  logic [psdd_pkg::SqW-1:0]  sq_r;
  logic [PW-1:0]             max_r;
  logic [PW-1:0]             min_r;
  logic [PW-1:0]             peak_r;
  logic [PW-1:0]             bdrop_r;
  logic [PW-1:0]             bpeak_r;
  logic                      ovf_r;
  logic [PW-1:0]             fin_r;
  logic [psdd_pkg::DivW-1:0] acc_r;
  logic [PW-1:0]             nn_r;
  logic [PW-1:0]             mean_r;
  logic [psdd_pkg::VarW-1:0] var_r;
  logic [psdd_pkg::VarW-1:0] x_r;
  logic [psdd_pkg::VarW-1:0] res_r;
  logic [psdd_pkg::VarW-1:0] bit_r;
  logic [psdd_pkg::DdW-1:0]  dd_r;
  psdd_pkg::out_word_t       out_r;

  logic [PW-1:0]             p;
  logic [2*PW-1:0]           p_sq;
  logic [PW-1:0]             peak_n;
  logic [PW-1:0]             drop;
  logic [2*PW-1:0]           lhs;
  logic [2*PW-1:0]           rhs;
  logic                      upd;
  logic [2*psdd_pkg::CntW-1:0] nn_full;
  logic [psdd_pkg::DivW-1:0] div_n;
  logic [PW-1:0]             div_d;
  logic [psdd_pkg::DivW-1:0] quo;
  logic                      div_done;
  logic [psdd_pkg::VarW-1:0] sq_t;
  logic                      sq_ge;
  logic [PW-1:0]             sd;

  assign p      = in_word.price;
  assign p_sq   = p * p;
  assign peak_n = (p > peak_r) ? p : peak_r;
  assign drop   = peak_n - p;
  assign lhs    = drop * bpeak_r;
  assign rhs    = bdrop_r * peak_n;
  assign upd    = (peak_n != '0) && (lhs > rhs);
  assign nn_full = cnt_r * (cnt_r - 1'b1);

  always_comb begin
    case (cmd.div_sel)
      psdd_pkg::DivMean: begin
        div_n = psdd_pkg::DivW'(sum_r);
        div_d = PW'(cnt_r);
      end
      psdd_pkg::DivVar: begin
        div_n = acc_r;
        div_d = nn_r;
      end
      psdd_pkg::DivDd: begin
        div_n = psdd_pkg::DivW'({bdrop_r, 16'h0000});
        div_d = bpeak_r;
      end
      default: begin
        div_n = '0;
        div_d = '1;
      end
    endcase
  end

  psdd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quo),
    .done     (div_done)
  );

  assign sq_t  = res_r + bit_r;
  assign sq_ge = x_r >= sq_t;
  assign sd    = (cnt_r < psdd_pkg::CntW'(2)) ? '0 :
                 (res_r[psdd_pkg::VarW-1:PW] != '0) ? '1 : res_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      max_r   <= '0;
      min_r   <= '1;
      peak_r  <= '0;
      bdrop_r <= '0;
      bpeak_r <= PW'(1);
      ovf_r   <= 1'b0;
    end else if (cmd.out_ld) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      max_r   <= '0;
      min_r   <= '1;
      peak_r  <= '0;
      bdrop_r <= '0;
      bpeak_r <= PW'(1);
      ovf_r   <= 1'b0;
    end else if (cmd.acc) begin
      if (cnt_r >= psdd_pkg::CntW'(psdd_pkg::MaxSamples)) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r  <= cnt_r + 1'b1;
        sum_r  <= sum_r + psdd_pkg::SumW'(p);
        sq_r   <= sq_r + psdd_pkg::SqW'(p_sq);
        peak_r <= peak_n;
        if (p > max_r) begin
          max_r <= p;
        end
        if (p < min_r) begin
          min_r <= p;
        end
        if (upd) begin
          bdrop_r <= drop;
          bpeak_r <= peak_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      fin_r <= p;
    end
    if (cmd.prep) begin
      acc_r <= '0;
      nn_r  <= nn_full[PW-1:0];
    end else if (cmd.mul_a) begin
      if (cnt_r[cmd.idx[3:0]]) begin
        acc_r <= acc_r + (psdd_pkg::DivW'(sq_r) << cmd.idx[3:0]);
      end
    end else if (cmd.mul_b) begin
      if (sum_r[cmd.idx]) begin
        acc_r <= acc_r - (psdd_pkg::DivW'(sum_r) << cmd.idx);
      end
    end
    if (cmd.div_ld) begin
      case (cmd.div_sel)
        psdd_pkg::DivMean: mean_r <= quo[PW-1:0];
        psdd_pkg::DivVar:  var_r <= quo[psdd_pkg::VarW-1:0];
        psdd_pkg::DivDd: begin
          dd_r <= (quo[psdd_pkg::DivW-1:psdd_pkg::DdW] != '0) ? '1 : quo[psdd_pkg::DdW-1:0];
        end
        default: mean_r <= mean_r;
      endcase
    end
    if (cmd.sqrt_init) begin
      x_r   <= var_r;
      res_r <= '0;
      bit_r <= psdd_pkg::VarW'(1) << (psdd_pkg::VarW - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_ge) begin
        x_r   <= x_r - sq_t;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.out_ld) begin
      out_r.mean_price   <= mean_r;
      out_r.std_dev      <= sd;
      out_r.max_price    <= max_r;
      out_r.min_price    <= min_r;
      out_r.final_price  <= fin_r;
      out_r.max_drawdown <= dd_r;
      out_r.sample_count <= cnt_r;
      out_r.too_long     <= ovf_r;
    end
  end

  assign sts.div_done = div_done;
  assign out_word     = out_r;

endmodule

// ===== rtl/core/psdd_ctrl.sv =====
`include "path_statistics_with_drawdown_defines.svh"

module psdd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic            out_stall,
  input  psdd_pkg::sts_t  sts,
  output logic            in_stall,
  output logic            out_valid,
  output psdd_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_ACC,
    S_PREP,
    S_MULA,
    S_MULB,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQ_INIT,
    S_SQRT,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [psdd_pkg::IdxW-1:0]   idx_r;
  psdd_pkg::div_sel_t          sel_r;
  logic                        out_valid_r;
  logic                        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_ACC);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.div_sel   = sel_r;
    cmd.acc       = (state_r == S_ACC) && in_valid;
    cmd.prep      = (state_r == S_PREP);
    cmd.mul_a     = (state_r == S_MULA);
    cmd.mul_b     = (state_r == S_MULB);
    cmd.div_start = (state_r == S_DIV_GO);
    cmd.div_ld    = (state_r == S_DIV_WAIT) && sts.div_done;
    cmd.sqrt_init = (state_r == S_SQ_INIT);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.out_ld    = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      idx_r       <= '0;
      sel_r       <= psdd_pkg::DivMean;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ACC: begin
          if (in_valid && in_last) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          idx_r   <= '0;
          state_r <= S_MULA;
        end
        S_MULA: begin
          if (idx_r == psdd_pkg::IdxW'(psdd_pkg::CntW - 1)) begin
            idx_r   <= '0;
            state_r <= S_MULB;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MULB: begin
          if (idx_r == psdd_pkg::IdxW'(psdd_pkg::SumW - 1)) begin
            idx_r   <= '0;
            sel_r   <= psdd_pkg::DivMean;
            state_r <= S_DIV_GO;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            case (sel_r)
              psdd_pkg::DivMean: begin
                sel_r   <= psdd_pkg::DivVar;
                state_r <= S_DIV_GO;
              end
              psdd_pkg::DivVar: state_r <= S_SQ_INIT;
              psdd_pkg::DivDd:  state_r <= S_DONE;
              default:          state_r <= S_ACC;
            endcase
          end
        end
        S_SQ_INIT: begin
          idx_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (idx_r == psdd_pkg::IdxW'(psdd_pkg::SqrtSteps - 1)) begin
            idx_r   <= '0;
            sel_r   <= psdd_pkg::DivDd;
            state_r <= S_DIV_GO;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  `PSDD_NEVER(a_done_only_waiting, clk, rst_n, sts.div_done && (state_r != S_DIV_WAIT), "divider finished outside a wait state")
  `PSDD_ASSERT(a_last_starts_finish, clk, rst_n, (state_r == S_ACC && in_valid && in_last) |=> (state_r == S_PREP), "last word did not start the finish sequence")
  `PSDD_ASSERT(a_done_emits, clk, rst_n, (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_ACC), "finished result was not presented")
  `PSDD_NEVER(a_idx_range, clk, rst_n, (state_r == S_MULB) && (idx_r > psdd_pkg::IdxW'(psdd_pkg::SumW - 1)), "step index out of range")

endmodule

// ===== rtl/core/path_statistics_with_drawdown.sv =====
// Path statistics with maximum drawdown. Prices (24-bit, 12 fraction bits) are taken one word
// per cycle while a path streams in. The word with last set closes the path, and the block then
// stalls its input while it finishes the result. That work is done by a shift-add multiplier,
// one shared restoring divider used three times for the mean, the variance and the drawdown
// fraction, and a digit-by-digit square root. The input stays stalled longer if the previous
// result is still held on the output. Samples beyond 4096 are not counted and set too_long.
module path_statistics_with_drawdown (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psdd_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psdd_pkg::out_word_t  out_word
);

  psdd_pkg::cmd_t cmd;
  psdd_pkg::sts_t sts;

  psdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_word.last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  psdd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
